// File: rtl/stlx_pkg.sv
// ----------------------------------------------------------------------------
// stlx_pkg
// Shared types, constants and the operator/keyword pattern table of the lexer.
// ----------------------------------------------------------------------------
package stlx_pkg;

    localparam int WINDOW_DEPTH = 8;
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);
    localparam int POS_W        = 16;
    localparam int KIND_W       = 6;
    localparam int ERR_W        = 2;
    localparam int DROP_W       = 3;
    localparam int PAT_LEN_MAX  = 7;
    localparam int NUM_ROWS     = 23;
    localparam int ROW_IDX_W    = $clog2(NUM_ROWS);

    localparam logic [KIND_W-1:0] KIND_INT = 6'd16;
    localparam logic [KIND_W-1:0] KIND_VAR = 6'd17;
    localparam logic [KIND_W-1:0] KIND_STR = 6'd18;
    localparam logic [KIND_W-1:0] KIND_ERR = 6'd35;
    localparam logic [KIND_W-1:0] KIND_END = 6'd36;

    localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNDEF  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_POINTS = 2'd2;
    localparam logic [ERR_W-1:0] ERR_UNTERM = 2'd3;

    typedef logic [WINDOW_DEPTH-1:0][7:0] win_t;

    // pattern text is right-justified: first byte sits highest
    typedef struct packed {
        logic [8*PAT_LEN_MAX-1:0] pat;
        logic [2:0]               len;
        logic [2:0]               adv;
        logic [KIND_W-1:0]        kind;
        logic                     bval;
    } row_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              ended;
        logic              seen_dp;
        logic              out_free;
        logic              c_blank;
        logic              c_space;
        logic              c_single;
        logic [KIND_W-1:0] single_kind;
        logic              c_digit;
        logic              c_at;
        logic              c_quote;
        logic              s_digit;
        logic              s_dot;
        logic              s_name;
        logic              s_quote;
        logic              row_hit;
        logic              row_wait;
        logic [KIND_W-1:0] row_kind;
        logic [2:0]        row_adv;
        logic              row_bval;
    } status_t;

    typedef struct packed {
        logic              append;
        logic [DROP_W-1:0] drop;
        logic              clear_fill;
        logic              clear_all;
        logic              set_tok;
        logic              dp_clr;
        logic              dp_set;
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic              use_c;
        logic              last;
        logic              bval;
        logic [ERR_W-1:0]  err;
        logic              use_tok;
    } cmd_t;

    // tried in this order; the first row that does not fail decides
    function automatic row_t row_info(input logic [ROW_IDX_W-1:0] idx);
        row_t r;
        r = '0;
        unique case (idx)
            5'd0:    r = '{"> ",      3'd2, 3'd2, 6'd10, 1'b0};
            5'd1:    r = '{">=",      3'd2, 3'd2, 6'd11, 1'b0};
            5'd2:    r = '{">>",      3'd2, 3'd2, 6'd12, 1'b0};
            5'd3:    r = '{"< ",      3'd2, 3'd2, 6'd13, 1'b0};
            5'd4:    r = '{"<=",      3'd2, 3'd2, 6'd14, 1'b0};
            5'd5:    r = '{"<<",      3'd2, 3'd2, 6'd15, 1'b0};
            5'd6:    r = '{"& ",      3'd2, 3'd2, 6'd19, 1'b0};
            5'd7:    r = '{"&&",      3'd2, 3'd2, 6'd20, 1'b0};
            5'd8:    r = '{"| ",      3'd2, 3'd2, 6'd21, 1'b0};
            5'd9:    r = '{"||",      3'd2, 3'd2, 6'd22, 1'b0};
            5'd10:   r = '{"!@",      3'd2, 3'd1, 6'd23, 1'b0};
            5'd11:   r = '{"!= ",     3'd3, 3'd3, 6'd24, 1'b0};
            5'd12:   r = '{"= ",      3'd2, 3'd2, 6'd25, 1'b0};
            5'd13:   r = '{"== ",     3'd3, 3'd3, 6'd26, 1'b0};
            5'd14:   r = '{"bool ",   3'd5, 3'd5, 6'd27, 1'b0};
            5'd15:   r = '{"elif ",   3'd5, 3'd5, 6'd28, 1'b0};
            5'd16:   r = '{"else",    3'd4, 3'd4, 6'd29, 1'b0};
            5'd17:   r = '{"endif",   3'd5, 3'd5, 6'd30, 1'b0};
            5'd18:   r = '{"if ",     3'd3, 3'd3, 6'd31, 1'b0};
            5'd19:   r = '{"int ",    3'd4, 3'd4, 6'd32, 1'b0};
            5'd20:   r = '{"string ", 3'd7, 3'd7, 6'd33, 1'b0};
            5'd21:   r = '{"true",    3'd4, 3'd4, 6'd34, 1'b1};
            5'd22:   r = '{"false",   3'd5, 3'd5, 6'd34, 1'b0};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/stlx_match.sv
// ----------------------------------------------------------------------------
// stlx_match
// Compares the lookahead window against the operator/keyword table.
// ----------------------------------------------------------------------------
module stlx_match (
    input  stlx_pkg::win_t                   win,
    input  logic [stlx_pkg::FILL_W-1:0]      fill,
    input  logic                             ended,
    output logic                             hit,
    output logic                             undecided,
    output logic [stlx_pkg::KIND_W-1:0]      kind,
    output logic [2:0]                       adv,
    output logic                             bval
);

    always_comb
    begin
        stlx_pkg::row_t ri;
        logic           fail;
        logic           found;
        hit       = 1'b0;
        undecided = 1'b0;
        kind      = '0;
        adv       = '0;
        bval      = 1'b0;
        found     = 1'b0;
        for (int r = 0; r < stlx_pkg::NUM_ROWS; r++)
        begin
            ri   = stlx_pkg::row_info(stlx_pkg::ROW_IDX_W'(r));
            fail = 1'b0;
            for (int i = 0; i < stlx_pkg::PAT_LEN_MAX; i++)
            begin
                if (i < int'(ri.len) && i < int'(fill))
                begin
                    if (win[i] != 8'(ri.pat >> (8 * (int'(ri.len) - 1 - i))))
                        fail = 1'b1;
                end
            end
            // short window at end of text can never complete the pattern
            if (int'(ri.len) > int'(fill) && ended)
                fail = 1'b1;
            if (!found && !fail)
            begin
                found = 1'b1;
                if (int'(ri.len) > int'(fill))
                    undecided = 1'b1;
                else
                begin
                    hit  = 1'b1;
                    kind = ri.kind;
                    adv  = ri.adv;
                    bval = ri.bval;
                end
            end
        end
    end

endmodule

// File: rtl/stlx_datapath.sv
// ----------------------------------------------------------------------------
// stlx_datapath
// Lookahead window, positions, byte classes and the result register.
// ----------------------------------------------------------------------------
module stlx_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [7:0]                    char_byte,
    input  logic                          end_of_text,
    input  stlx_pkg::cmd_t                cmd,
    output stlx_pkg::status_t             st,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [stlx_pkg::KIND_W-1:0]   token_kind,
    output logic [7:0]                    value_byte,
    output logic                          value_valid,
    output logic                          token_last,
    output logic                          bool_value,
    output logic [stlx_pkg::ERR_W-1:0]    error_code,
    output logic [stlx_pkg::POS_W-1:0]    start_position
);

    stlx_pkg::win_t                  win_reg;
    stlx_pkg::win_t                  win_next;
    logic [stlx_pkg::FILL_W-1:0]     fill_reg;
    logic [stlx_pkg::POS_W-1:0]      pos_reg;
    logic [stlx_pkg::POS_W-1:0]      tok_reg;
    logic                            dp_reg;
    logic                            ended_reg;
    logic                            out_valid_reg;
    logic [stlx_pkg::KIND_W-1:0]     kind_reg;
    logic [7:0]                      vbyte_reg;
    logic                            vvalid_reg;
    logic                            last_reg;
    logic                            bval_reg;
    logic [stlx_pkg::ERR_W-1:0]      err_reg;
    logic [stlx_pkg::POS_W-1:0]      spos_reg;
    logic [7:0]                      c;
    logic [7:0]                      s;
    logic                            has_room;
    logic                            m_hit;
    logic                            m_wait;
    logic [stlx_pkg::KIND_W-1:0]     m_kind;
    logic [2:0]                      m_adv;
    logic                            m_bval;
    logic                            c_single;
    logic [stlx_pkg::KIND_W-1:0]     single_kind;

    assign c        = win_reg[0];
    assign s        = win_reg[1];
    assign has_room = fill_reg < stlx_pkg::FILL_W'(stlx_pkg::WINDOW_DEPTH);

    stlx_match u_match (
        .win       (win_reg),
        .fill      (fill_reg),
        .ended     (ended_reg),
        .hit       (m_hit),
        .undecided (m_wait),
        .kind      (m_kind),
        .adv       (m_adv),
        .bval      (m_bval)
    );

    always_comb
    begin
        c_single    = 1'b1;
        single_kind = '0;
        unique case (c)
            8'h0A:   single_kind = 6'd0;
            "(":     single_kind = 6'd1;
            ")":     single_kind = 6'd2;
            "+":     single_kind = 6'd3;
            "-":     single_kind = 6'd4;
            "*":     single_kind = 6'd5;
            "/":     single_kind = 6'd6;
            "%":     single_kind = 6'd7;
            "^":     single_kind = 6'd8;
            "~":     single_kind = 6'd9;
            default: c_single    = 1'b0;
        endcase
    end

    always_comb
    begin
        st             = '0;
        st.fill        = fill_reg;
        st.ended       = ended_reg;
        st.seen_dp     = dp_reg;
        st.out_free    = !out_valid_reg || !out_stall;
        st.c_blank     = (c == " ") || (c == 8'h09);
        st.c_space     = (c == " ") || (c >= 8'h09 && c <= 8'h0D && c != 8'h0A);
        st.c_single    = c_single;
        st.single_kind = single_kind;
        st.c_digit     = (c >= "0") && (c <= "9");
        st.c_at        = (c == "@");
        st.c_quote     = (c == 8'h22);
        st.s_digit     = (s >= "0") && (s <= "9");
        st.s_dot       = (s == ".");
        st.s_name      = ((s >= "0") && (s <= "9")) || ((s >= "a") && (s <= "z"))
                         || ((s >= "A") && (s <= "Z")) || (s == "_");
        st.s_quote     = (s == 8'h22);
        st.row_hit     = m_hit;
        st.row_wait    = m_wait;
        st.row_kind    = m_kind;
        st.row_adv     = m_adv;
        st.row_bval    = m_bval;
    end

    always_comb
    begin
        logic [stlx_pkg::IDX_W:0] src;
        win_next = win_reg;
        src      = '0;
        if (cmd.append)
        begin
            if (has_room)
                win_next[fill_reg[stlx_pkg::IDX_W-1:0]] = char_byte;
        end
        else if (cmd.drop != '0)
        begin
            for (int i = 0; i < stlx_pkg::WINDOW_DEPTH; i++)
            begin
                src = (stlx_pkg::IDX_W + 1)'(i) + (stlx_pkg::IDX_W + 1)'(cmd.drop);
                if (src < (stlx_pkg::IDX_W + 1)'(stlx_pkg::WINDOW_DEPTH))
                    win_next[i] = win_reg[src[stlx_pkg::IDX_W-1:0]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            pos_reg   <= '0;
            tok_reg   <= '0;
            dp_reg    <= 1'b0;
            ended_reg <= 1'b0;
        end
        else if (cmd.clear_all)
        begin
            fill_reg  <= '0;
            pos_reg   <= '0;
            tok_reg   <= '0;
            dp_reg    <= 1'b0;
            ended_reg <= 1'b0;
        end
        else
        begin
            if (cmd.append)
            begin
                if (has_room)
                    fill_reg <= fill_reg + 1'b1;
                ended_reg <= end_of_text;
            end
            if (cmd.clear_fill)
                fill_reg <= '0;
            else if (cmd.drop != '0)
            begin
                fill_reg <= fill_reg - stlx_pkg::FILL_W'(cmd.drop);
                pos_reg  <= pos_reg + stlx_pkg::POS_W'(cmd.drop);
            end
            if (cmd.set_tok)
                tok_reg <= pos_reg;
            if (cmd.dp_clr)
                dp_reg <= 1'b0;
            else if (cmd.dp_set)
                dp_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg   <= cmd.kind;
            vbyte_reg  <= cmd.use_c ? c : 8'h00;
            vvalid_reg <= cmd.use_c;
            last_reg   <= cmd.last;
            bval_reg   <= cmd.bval;
            err_reg    <= cmd.err;
            spos_reg   <= cmd.use_tok ? tok_reg : pos_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign token_kind     = kind_reg;
    assign value_byte     = vbyte_reg;
    assign value_valid    = vvalid_reg;
    assign token_last     = last_reg;
    assign bool_value     = bval_reg;
    assign error_code     = err_reg;
    assign start_position = spos_reg;

endmodule

// File: rtl/stlx_ctrl.sv
// ----------------------------------------------------------------------------
// stlx_ctrl
// Scan-mode state machine: one window step per cycle unless a held result stalls it, one result at most.
// ----------------------------------------------------------------------------
module stlx_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 end_of_text,
    input  stlx_pkg::status_t    st,
    output stlx_pkg::cmd_t       cmd,
    output logic                 ready
);

    localparam logic PH_ACCEPT = 1'b0;
    localparam logic PH_SCAN   = 1'b1;

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_BLANK = 3'd1;
    localparam logic [2:0] MODE_INT   = 3'd2;
    localparam logic [2:0] MODE_VAR   = 3'd3;
    localparam logic [2:0] MODE_STR   = 3'd4;
    localparam logic [2:0] MODE_HALT  = 3'd5;

    logic       phase_reg;
    logic       phase_next;
    logic [2:0] mode_reg;
    logic [2:0] mode_next;

    always_comb
    begin
        logic finish;
        logic more;
        cmd        = '0;
        ready      = 1'b0;
        phase_next = phase_reg;
        mode_next  = mode_reg;
        finish     = 1'b0;
        more       = 1'b0;
        unique case (phase_reg)
            PH_ACCEPT:
            begin
                ready = 1'b1;
                if (in_valid)
                begin
                    if (mode_reg == MODE_HALT)
                    begin
                        if (end_of_text)
                        begin
                            cmd.clear_all = 1'b1;
                            mode_next     = MODE_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.append = 1'b1;
                        phase_next = PH_SCAN;
                    end
                end
            end
            PH_SCAN:
            begin
                if (st.fill == '0 || mode_reg == MODE_HALT)
                    finish = 1'b1;
                else
                begin
                    unique case (mode_reg) inside
                        MODE_IDLE:
                        begin
                            cmd.set_tok = 1'b1;
                            if (st.c_blank)
                            begin
                                cmd.drop  = 3'd1;
                                mode_next = MODE_BLANK;
                            end
                            else if (st.c_single)
                            begin
                                cmd.emit = 1'b1;
                                cmd.kind = st.single_kind;
                                cmd.last = 1'b1;
                                cmd.drop = 3'd1;
                            end
                            else if (st.c_digit)
                            begin
                                cmd.dp_clr = 1'b1;
                                mode_next  = MODE_INT;
                            end
                            else if (st.c_at)
                                mode_next = MODE_VAR;
                            else if (st.c_quote)
                            begin
                                cmd.drop  = 3'd1;
                                mode_next = MODE_STR;
                            end
                            else if (st.row_wait)
                                finish = 1'b1;
                            else if (st.row_hit)
                            begin
                                cmd.emit = 1'b1;
                                cmd.kind = st.row_kind;
                                cmd.bval = st.row_bval;
                                cmd.last = 1'b1;
                                cmd.drop = st.row_adv;
                            end
                            else
                            begin
                                // byte starts no token: report it and skip it
                                cmd.emit  = 1'b1;
                                cmd.kind  = stlx_pkg::KIND_ERR;
                                cmd.use_c = 1'b1;
                                cmd.err   = stlx_pkg::ERR_UNDEF;
                                cmd.last  = 1'b1;
                                cmd.drop  = 3'd1;
                            end
                        end
                        MODE_BLANK:
                        begin
                            if (st.c_space)
                                cmd.drop = 3'd1;
                            else
                                mode_next = MODE_IDLE;
                        end
                        MODE_INT, MODE_VAR:
                        begin
                            if (st.fill == stlx_pkg::FILL_W'(1))
                            begin
                                if (st.ended)
                                begin
                                    cmd.emit    = 1'b1;
                                    cmd.kind    = (mode_reg == MODE_INT) ? stlx_pkg::KIND_INT
                                                                         : stlx_pkg::KIND_VAR;
                                    cmd.use_c   = 1'b1;
                                    cmd.last    = 1'b1;
                                    cmd.use_tok = 1'b1;
                                    cmd.drop    = 3'd1;
                                    mode_next   = MODE_IDLE;
                                end
                                else
                                    finish = 1'b1;
                            end
                            else if (mode_reg == MODE_INT && st.s_dot && st.seen_dp)
                            begin
                                cmd.emit       = 1'b1;
                                cmd.kind       = stlx_pkg::KIND_ERR;
                                cmd.err        = stlx_pkg::ERR_POINTS;
                                cmd.last       = 1'b1;
                                cmd.use_tok    = 1'b1;
                                cmd.clear_fill = 1'b1;
                                mode_next      = MODE_HALT;
                            end
                            else
                            begin
                                if (mode_reg == MODE_INT)
                                begin
                                    more       = st.s_digit || st.s_dot;
                                    cmd.dp_set = st.s_dot;
                                    cmd.kind   = stlx_pkg::KIND_INT;
                                end
                                else
                                begin
                                    more     = st.s_name;
                                    cmd.kind = stlx_pkg::KIND_VAR;
                                end
                                cmd.emit    = 1'b1;
                                cmd.use_c   = 1'b1;
                                cmd.last    = !more;
                                cmd.use_tok = 1'b1;
                                cmd.drop    = 3'd1;
                                if (!more)
                                    mode_next = MODE_IDLE;
                            end
                        end
                        MODE_STR:
                        begin
                            if (st.c_quote)
                            begin
                                // empty string
                                cmd.emit    = 1'b1;
                                cmd.kind    = stlx_pkg::KIND_STR;
                                cmd.last    = 1'b1;
                                cmd.use_tok = 1'b1;
                                cmd.drop    = 3'd1;
                                mode_next   = MODE_IDLE;
                            end
                            else if (st.fill == stlx_pkg::FILL_W'(1))
                            begin
                                if (st.ended)
                                begin
                                    cmd.emit       = 1'b1;
                                    cmd.kind       = stlx_pkg::KIND_ERR;
                                    cmd.err        = stlx_pkg::ERR_UNTERM;
                                    cmd.last       = 1'b1;
                                    cmd.use_tok    = 1'b1;
                                    cmd.clear_fill = 1'b1;
                                    mode_next      = MODE_HALT;
                                end
                                else
                                    finish = 1'b1;
                            end
                            else
                            begin
                                // closing quote is swallowed with the last byte
                                cmd.emit    = 1'b1;
                                cmd.kind    = stlx_pkg::KIND_STR;
                                cmd.use_c   = 1'b1;
                                cmd.last    = st.s_quote;
                                cmd.use_tok = 1'b1;
                                cmd.drop    = st.s_quote ? 3'd2 : 3'd1;
                                if (st.s_quote)
                                    mode_next = MODE_IDLE;
                            end
                        end
                        default: finish = 1'b1;
                    endcase
                end
                if (finish)
                begin
                    phase_next = PH_ACCEPT;
                    if (st.ended)
                    begin
                        cmd.clear_all = 1'b1;
                        mode_next     = MODE_IDLE;
                        if (mode_reg == MODE_STR)
                        begin
                            cmd.emit    = 1'b1;
                            cmd.kind    = stlx_pkg::KIND_ERR;
                            cmd.err     = stlx_pkg::ERR_UNTERM;
                            cmd.last    = 1'b1;
                            cmd.use_tok = 1'b1;
                        end
                        else if (mode_reg == MODE_BLANK)
                        begin
                            cmd.emit = 1'b1;
                            cmd.kind = stlx_pkg::KIND_END;
                            cmd.last = 1'b1;
                        end
                    end
                end
            end
            default: phase_next = PH_ACCEPT;
        endcase
        // result register still occupied: hold the whole step
        if (cmd.emit && !st.out_free)
        begin
            cmd        = '0;
            phase_next = phase_reg;
            mode_next  = mode_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ACCEPT;
            mode_reg  <= MODE_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

// File: rtl/script_token_lexer.sv
// ----------------------------------------------------------------------------
// script_token_lexer
// Streaming tokenizer: bytes in, tokens and value-byte runs out.
// ----------------------------------------------------------------------------
// Each byte is taken in the accept phase; the scan phase then runs window
// steps (a mode change or one result each) and a closing step.
// Results leave through a register in the cycle after their step; a stalled
// result holds the scan step. A byte arriving in halt skips the scan phase.
// Reset clears all control state; window contents are undefined until written.
// ----------------------------------------------------------------------------
module script_token_lexer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    char_byte,
    input  logic                          end_of_text,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [stlx_pkg::KIND_W-1:0]   token_kind,
    output logic [7:0]                    value_byte,
    output logic                          value_valid,
    output logic                          token_last,
    output logic                          bool_value,
    output logic [stlx_pkg::ERR_W-1:0]    error_code,
    output logic [stlx_pkg::POS_W-1:0]    start_position
);

    stlx_pkg::cmd_t    cmd;
    stlx_pkg::status_t st;
    logic              ready;

    assign in_stall = !ready;

    stlx_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .end_of_text (end_of_text),
        .st          (st),
        .cmd         (cmd),
        .ready       (ready)
    );

    stlx_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_byte      (char_byte),
        .end_of_text    (end_of_text),
        .cmd            (cmd),
        .st             (st),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .token_kind     (token_kind),
        .value_byte     (value_byte),
        .value_valid    (value_valid),
        .token_last     (token_last),
        .bool_value     (bool_value),
        .error_code     (error_code),
        .start_position (start_position)
    );

endmodule
